### rtl/led_matrix_bitplane_refresh_defines.svh
// Assertion helpers for the refresh engine, clocked on clk, quiet during rst.
`ifndef LED_MATRIX_BITPLANE_REFRESH_DEFINES_SVH
`define LED_MATRIX_BITPLANE_REFRESH_DEFINES_SVH

// Same-cycle implication.
`define LMBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LMBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lmbr_pkg.sv
package lmbr_pkg;

  localparam int PLANES_DEF  = 4;
  localparam int COLUMNS_DEF = 64;
  localparam int SCAN_ROWS   = 16;
  localparam int ROW_W       = 4;
  localparam int X_W         = 6;
  localparam int Y_W         = 5;
  localparam int LEVEL_W     = 4;
  localparam int DATA_W      = 6;
  localparam int TRIPLE_W    = 3;
  localparam int PERIOD_W    = 13;
  localparam int HOLD_W      = 16;
  localparam int PLANE_OUT_W = 2;

  localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST = 13'd1110;
  localparam logic [HOLD_W-1:0]   HOLD_MAX        = 16'hFFFF;

  // Input command codes.
  localparam logic CMD_WRITE_PIXEL = 1'b0;
  localparam logic CMD_REFRESH     = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STREAM,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic clear_en;
    logic pixel_we;
    logic advance;
    logic read_en;
  } lmbr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic col_last;
  } lmbr_stat_t;

endpackage

### rtl/lmbr_ctrl.sv
module lmbr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  lmbr_pkg::lmbr_stat_t stat,
  output lmbr_pkg::lmbr_cmd_t  cmd,
  output logic               busy
);
  import lmbr_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (command == CMD_REFRESH) begin
            cmd.advance = 1'b1;
            state_next  = ST_STREAM;
          end else begin
            cmd.pixel_we = 1'b1;
          end
        end
      end
      ST_STREAM: begin
        cmd.read_en = 1'b1;
        if (stat.col_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last column is on the result ports this cycle
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/lmbr_datapath.sv
module lmbr_datapath #(
  parameter int PLANES  = lmbr_pkg::PLANES_DEF,
  parameter int COLUMNS = lmbr_pkg::COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lmbr_pkg::lmbr_cmd_t             cmd,
  output lmbr_pkg::lmbr_stat_t            stat,
  input  logic [lmbr_pkg::X_W-1:0]        x,
  input  logic [lmbr_pkg::Y_W-1:0]        y,
  input  logic [lmbr_pkg::LEVEL_W-1:0]    red,
  input  logic [lmbr_pkg::LEVEL_W-1:0]    green,
  input  logic [lmbr_pkg::LEVEL_W-1:0]    blue,
  input  logic                            cfg_we,
  input  logic [lmbr_pkg::PERIOD_W-1:0]   cfg_data,
  output logic                            strobe,
  output logic [lmbr_pkg::DATA_W-1:0]     column_data,
  output logic [lmbr_pkg::ROW_W-1:0]      row_address,
  output logic [lmbr_pkg::PLANE_OUT_W-1:0] plane,
  output logic [lmbr_pkg::HOLD_W-1:0]     hold_cycles,
  output logic                            last_column
);
  import lmbr_pkg::*;

  localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = SCAN_ROWS << COL_W;
  localparam int WORD_W  = TRIPLE_W * PLANES;
  localparam int XC_W    = X_W + 1;

  // One word per (row, column), all planes side by side; upper and lower half panels apart.
  logic [WORD_W-1:0] mem_up [DEPTH];
  logic [WORD_W-1:0] mem_lo [DEPTH];

  logic [ADDR_W-1:0]   clear_cnt;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    scan_row;
  logic [PLANE_W-1:0]  plane_index;
  logic [PERIOD_W-1:0] base_period;
  logic [WORD_W-1:0]   word_up;
  logic [WORD_W-1:0]   word_lo;

  logic                x_ok;
  logic [XC_W-1:0]     col_rev;
  logic [ADDR_W-1:0]   waddr;
  logic [WORD_W-1:0]   wdata;
  logic                we_up;
  logic                we_lo;
  logic [7:0]          red_x;
  logic [7:0]          green_x;
  logic [7:0]          blue_x;
  logic                plane_wrap;
  logic [31:0]         hold_wide;
  logic [31:0]         plane_ext;

  assign stat.clear_last = (clear_cnt == ADDR_W'(DEPTH - 1));
  assign stat.col_last   = (col == COL_W'(COLUMNS - 1));

  assign x_ok    = ({1'b0, x} < XC_W'(COLUMNS));
  assign col_rev = XC_W'(COLUMNS - 1) - {1'b0, x};
  assign red_x   = 8'(red);
  assign green_x = 8'(green);
  assign blue_x  = 8'(blue);

  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      wdata[p*TRIPLE_W +: TRIPLE_W] = {blue_x[p], green_x[p], red_x[p]};
    end
    if (cmd.clear_en) begin
      waddr = clear_cnt;
      wdata = '0;
      we_up = 1'b1;
      we_lo = 1'b1;
    end else begin
      waddr = {y[ROW_W-1:0], col_rev[COL_W-1:0]};
      we_up = cmd.pixel_we && x_ok && !y[Y_W-1];
      we_lo = cmd.pixel_we && x_ok && y[Y_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (we_up) begin
      mem_up[waddr] <= wdata;
    end
    if (we_lo) begin
      mem_lo[waddr] <= wdata;
    end
    if (cmd.read_en) begin
      word_up <= mem_up[{scan_row, col}];
      word_lo <= mem_lo[{scan_row, col}];
    end
  end

  assign plane_wrap = (plane_index == PLANE_W'(PLANES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt   <= '0;
      col         <= '0;
      scan_row    <= ROW_W'(SCAN_ROWS - 1);
      plane_index <= PLANE_W'(PLANES - 1);
      base_period <= BASE_PERIOD_RST;
      strobe      <= 1'b0;
      last_column <= 1'b0;
    end else begin
      if (cmd.clear_en) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (cfg_we) begin
        base_period <= cfg_data;
      end
      if (cmd.advance) begin
        if (plane_wrap) begin
          plane_index <= '0;
          scan_row    <= scan_row + 1'b1;
        end else begin
          plane_index <= plane_index + 1'b1;
        end
      end
      if (cmd.read_en) begin
        col <= stat.col_last ? '0 : col + 1'b1;
      end
      strobe      <= cmd.read_en;
      last_column <= cmd.read_en && stat.col_last;
    end
  end

  assign plane_ext   = 32'(plane_index);
  assign plane       = plane_ext[PLANE_OUT_W-1:0];
  assign row_address = scan_row;
  assign column_data = {word_lo[plane_ext*TRIPLE_W +: TRIPLE_W],
                        word_up[plane_ext*TRIPLE_W +: TRIPLE_W]};
  assign hold_wide   = 32'(base_period) << plane_index;
  assign hold_cycles = (hold_wide > 32'(HOLD_MAX)) ? HOLD_MAX : hold_wide[HOLD_W-1:0];

endmodule

### rtl/led_matrix_bitplane_refresh.sv
// Refresh engine for a two-panel RGB LED matrix, 1/16 scan, binary code modulation.
//
// Input: start with command, x, y, red, green, blue; transfer happens on a clock edge
// with start high and busy low. command 0 writes a pixel: each level bit goes to its
// bit plane at reversed column COLUMNS-1-x, rows 0..15 to R1 G1 B1 and rows 16..31 to
// R2 G2 B2; x >= COLUMNS is dropped. A pixel write leaves busy low.
// command 1 is a refresh tick: advance the plane, and the row on plane wrap, then
// stream COLUMNS results, one per cycle, marked by strobe. Each result comes from a
// registered frame store read; last_column marks the final one. busy is high through
// the ST_STREAM and ST_FLUSH states after the tick, while the frame store's read
// ports walk one column per cycle.
// The receiver has no stall: each result is valid for exactly its strobe cycle.
// Configuration: cfg_valid/cfg_ready/cfg_data write base_period (ready is always high).
// hold_cycles is base_period shifted left by plane, saturated to 16 bits.
// Reset: row 15 and plane PLANES-1 so the first tick shows row 0, plane 0; base_period
// goes to 1110. The frame store is then swept to black, one address per cycle, over
// all 16 * 2^clog2(COLUMNS) addresses (1024 at 64 columns) with busy held high.
module led_matrix_bitplane_refresh #(
  parameter int PLANES  = lmbr_pkg::PLANES_DEF,
  parameter int COLUMNS = lmbr_pkg::COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command,
  input  logic [lmbr_pkg::X_W-1:0]         x,
  input  logic [lmbr_pkg::Y_W-1:0]         y,
  input  logic [lmbr_pkg::LEVEL_W-1:0]     red,
  input  logic [lmbr_pkg::LEVEL_W-1:0]     green,
  input  logic [lmbr_pkg::LEVEL_W-1:0]     blue,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lmbr_pkg::PERIOD_W-1:0]    cfg_data,
  output logic                             strobe,
  output logic [lmbr_pkg::DATA_W-1:0]      column_data,
  output logic [lmbr_pkg::ROW_W-1:0]       row_address,
  output logic [lmbr_pkg::PLANE_OUT_W-1:0] plane,
  output logic [lmbr_pkg::HOLD_W-1:0]      hold_cycles,
  output logic                             last_column
);
  import lmbr_pkg::*;

`include "led_matrix_bitplane_refresh_defines.svh"

  lmbr_cmd_t  cmd;
  lmbr_stat_t stat;

  // Register write is always accepted.
  assign cfg_ready = 1'b1;

  lmbr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  lmbr_datapath #(
    .PLANES  (PLANES),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .x           (x),
    .y           (y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .column_data (column_data),
    .row_address (row_address),
    .plane       (plane),
    .hold_cycles (hold_cycles),
    .last_column (last_column)
  );

  // Results only come out while a tick is in progress.
  `LMBR_ASSERT_NOW(a_strobe_busy, strobe, busy, "result strobe while idle")
  `LMBR_ASSERT_NOW(a_last_strobe, last_column, strobe, "last_column without strobe")
  // A tick run is gapless until its last column.
  `LMBR_ASSERT_NEXT(a_run_gapless, strobe && !last_column, strobe, "gap in column run")
  `LMBR_ASSERT_NEXT(a_tick_busy, start && !busy && command, busy, "tick did not raise busy")

endmodule

### sim/refresh_checker.sv
`timescale 1ns / 1ps

module refresh_checker
  import lmbr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     command,
  input  logic [X_W-1:0]           x,
  input  logic [Y_W-1:0]           y,
  input  logic [LEVEL_W-1:0]       red,
  input  logic [LEVEL_W-1:0]       green,
  input  logic [LEVEL_W-1:0]       blue,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [PERIOD_W-1:0]      cfg_data,
  input  logic                     strobe,
  input  logic [DATA_W-1:0]        column_data,
  input  logic [ROW_W-1:0]         row_address,
  input  logic [PLANE_OUT_W-1:0]   plane,
  input  logic [HOLD_W-1:0]        hold_cycles,
  input  logic                     last_column,
  output int                       fail_count,
  output int                       pending_count,
  output int                       column_count
);

  localparam int PLANES  = PLANES_DEF;
  localparam int COLUMNS = COLUMNS_DEF;
  localparam int LINES   = SCAN_ROWS * PLANES;

  typedef struct packed {
    logic [DATA_W-1:0]      data;
    logic [ROW_W-1:0]       row;
    logic [PLANE_OUT_W-1:0] plane;
    logic [HOLD_W-1:0]      hold;
    logic                   last;
  } column_beat_t;

  logic [DATA_W-1:0]   bitplane [LINES][COLUMNS];
  int                  scan_row;
  int                  plane_idx;
  logic [PERIOD_W-1:0] base_period;
  column_beat_t        column_q [$];
  int                  mismatches;
  int                  matched;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    column_count  = 0;
    mismatches    = 0;
    matched       = 0;
  end

  // Split the levels into bit planes at the mirrored column.
  task automatic store_pixel(input logic [X_W-1:0] px, input logic [Y_W-1:0] py,
                             input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                             input logic [LEVEL_W-1:0] b);
    int col;
    int line;
    logic [TRIPLE_W-1:0] bits;
    if (px >= COLUMNS) return;
    col = COLUMNS - 1 - int'(px);
    for (int p = 0; p < PLANES; p++) begin
      bits = (p < LEVEL_W) ? {b[p], g[p], r[p]} : '0;
      line = (int'(py) % SCAN_ROWS) + p * SCAN_ROWS;
      if (int'(py) >= SCAN_ROWS) bitplane[line][col][5:3] = bits;
      else bitplane[line][col][2:0] = bits;
    end
  endtask

  // Step plane then row, and queue one beat per column.
  task automatic queue_row_plane();
    logic [HOLD_W:0] wide;
    column_beat_t beat;
    int line;
    if (plane_idx + 1 >= PLANES) begin
      plane_idx = 0;
      scan_row  = (scan_row + 1) % SCAN_ROWS;
    end else begin
      plane_idx++;
    end
    wide = '0;
    wide[PERIOD_W-1:0] = base_period;
    wide = wide << plane_idx;
    line = scan_row + plane_idx * SCAN_ROWS;
    for (int k = 0; k < COLUMNS; k++) begin
      beat.data  = bitplane[line][k];
      beat.row   = ROW_W'(scan_row);
      beat.plane = PLANE_OUT_W'(plane_idx);
      beat.hold  = (wide > HOLD_MAX) ? HOLD_MAX : wide[HOLD_W-1:0];
      beat.last  = (k == COLUMNS - 1);
      column_q.push_back(beat);
    end
  endtask

  task automatic check_beat();
    column_beat_t want;
    if (column_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected column beat data=%h row=%0d plane=%0d hold=%0d last=%b",
                 $realtime, column_data, row_address, plane, hold_cycles, last_column);
      return;
    end
    want = column_q.pop_front();
    if (column_data !== want.data || row_address !== want.row || plane !== want.plane ||
        hold_cycles !== want.hold || last_column !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: column beat mismatch", $realtime);
        $display("  expected data=%h row=%0d plane=%0d hold=%0d last=%b",
                 want.data, want.row, want.plane, want.hold, want.last);
        $display("  actual   data=%h row=%0d plane=%0d hold=%0d last=%b",
                 column_data, row_address, plane, hold_cycles, last_column);
      end
    end else begin
      matched++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LINES; l++)
        for (int c = 0; c < COLUMNS; c++)
          bitplane[l][c] = '0;
      scan_row    = SCAN_ROWS - 1;
      plane_idx   = PLANES - 1;
      base_period = BASE_PERIOD_RST;
      column_q.delete();
    end else begin
      if (strobe) check_beat();
      if (cfg_valid && cfg_ready) base_period = cfg_data;
      if (start && !busy) begin
        if (command == CMD_REFRESH) queue_row_plane();
        else store_pixel(x, y, red, green, blue);
      end
    end
    fail_count    <= mismatches;
    pending_count <= column_q.size();
    column_count  <= matched;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import lmbr_pkg::*;

  // Cycles without any transfer before the run is abandoned; covers the
  // frame store sweep of 1024 addresses after reset with plenty of margin.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last result, well above the registered read path.
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 50;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   command;
  logic [X_W-1:0]         x;
  logic [Y_W-1:0]         y;
  logic [LEVEL_W-1:0]     red;
  logic [LEVEL_W-1:0]     green;
  logic [LEVEL_W-1:0]     blue;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [PERIOD_W-1:0]    cfg_data;
  logic                   strobe;
  logic [DATA_W-1:0]      column_data;
  logic [ROW_W-1:0]       row_address;
  logic [PLANE_OUT_W-1:0] plane;
  logic [HOLD_W-1:0]      hold_cycles;
  logic                   last_column;

  int fail_count;
  int pending_count;
  int column_count;
  int quiet_cycles = 0;
  int pixel_writes = 0;
  int refresh_ticks = 0;
  bit idle_on = 1'b0;

  led_matrix_bitplane_refresh dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .x           (x),
    .y           (y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .column_data (column_data),
    .row_address (row_address),
    .plane       (plane),
    .hold_cycles (hold_cycles),
    .last_column (last_column)
  );

  refresh_checker chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .x             (x),
    .y             (y),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .strobe        (strobe),
    .column_data   (column_data),
    .row_address   (row_address),
    .plane         (plane),
    .hold_cycles   (hold_cycles),
    .last_column   (last_column),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .column_count  (column_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Restart the count on any transfer: input, register write or column beat.
  // Reset counts as activity so the clearing sweep starts from zero.
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item and hold it until the block takes it. Leave start high
  // on return so a back-to-back item does not drop it in between.
  task automatic send_item(input logic cmd, input logic [X_W-1:0] px,
                           input logic [Y_W-1:0] py, input logic [LEVEL_W-1:0] r,
                           input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] b);
    start   <= 1'b1;
    command <= cmd;
    x       <= px;
    y       <= py;
    red     <= r;
    green   <= g;
    blue    <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_REFRESH) refresh_ticks++;
    else pixel_writes++;
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted beat has come out and the block is idle,
  // then give it a few more cycles in case a pixel write is still landing.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [PERIOD_W-1:0] period);
    cfg_valid <= 1'b1;
    cfg_data  <= period;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly refresh ticks and writes aimed at the row the next tick shows,
  // so written pixels actually reach the outputs; the rest go anywhere.
  task automatic random_item();
    int row;
    logic [Y_W-1:0] py;
    if ($urandom_range(0, 99) < 35) begin
      send_item(CMD_REFRESH, X_W'($urandom_range(0, 63)), Y_W'($urandom_range(0, 31)),
                LEVEL_W'($urandom_range(0, 15)), LEVEL_W'($urandom_range(0, 15)),
                LEVEL_W'($urandom_range(0, 15)));
    end else begin
      row = (refresh_ticks / PLANES_DEF) % SCAN_ROWS;
      if ($urandom_range(0, 9) < 7) py = Y_W'(row + SCAN_ROWS * $urandom_range(0, 1));
      else py = Y_W'($urandom_range(0, 31));
      send_item(CMD_WRITE_PIXEL, X_W'($urandom_range(0, 63)), py,
                LEVEL_W'($urandom_range(0, 15)), LEVEL_W'($urandom_range(0, 15)),
                LEVEL_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] period;
    rst       <= 1'b1;
    start     <= 1'b0;
    command   <= CMD_WRITE_PIXEL;
    x         <= '0;
    y         <= '0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait out the frame store sweep, then set the widest hold time.
    @(posedge clk);
    while (busy) @(posedge clk);
    write_base(13'd8191);

    // Directed: corner columns, both panel halves, full and empty levels,
    // an overwrite of one half that must leave the other half alone.
    send_item(CMD_WRITE_PIXEL, 6'd0,  5'd0,  4'hF, 4'hF, 4'hF);
    send_item(CMD_WRITE_PIXEL, 6'd63, 5'd0,  4'hF, 4'h0, 4'h0);
    send_item(CMD_WRITE_PIXEL, 6'd0,  5'd16, 4'h0, 4'hF, 4'h0);
    send_item(CMD_WRITE_PIXEL, 6'd63, 5'd16, 4'h0, 4'h0, 4'hF);
    send_item(CMD_WRITE_PIXEL, 6'd31, 5'd0,  4'hA, 4'h5, 4'h3);
    send_item(CMD_WRITE_PIXEL, 6'd32, 5'd16, 4'h5, 4'hA, 4'hC);
    send_item(CMD_WRITE_PIXEL, 6'd0,  5'd0,  4'h0, 4'h0, 4'h0);
    send_item(CMD_WRITE_PIXEL, 6'd17, 5'd31, 4'hF, 4'hF, 4'hF);
    send_item(CMD_WRITE_PIXEL, 6'd17, 5'd15, 4'h9, 4'h6, 4'hF);
    // Show row 0 through all four planes.
    repeat (4) send_item(CMD_REFRESH, 6'd63, 5'd31, 4'hF, 4'hF, 4'hF);
    send_item(CMD_WRITE_PIXEL, 6'd5, 5'd1,  4'hF, 4'hF, 4'hF);
    send_item(CMD_WRITE_PIXEL, 6'd5, 5'd17, 4'hF, 4'h0, 4'hF);
    // Row 1, planes 0..3, back to back.
    repeat (4) send_item(CMD_REFRESH, 6'd0, 5'd0, 4'h0, 4'h0, 4'h0);
    settle();

    // Random phases, each under its own hold time: zero, one, two
    // random values, then the reset value. Phase 2 and the final phase run
    // without idling; the others pause in short bursts.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: period = '0;
        1: period = 13'd1;
        4: period = BASE_PERIOD_RST;
        default: period = PERIOD_W'($urandom_range(1, 8191));
      endcase
      idle_on = (ph != 2) && (ph != 4);
      write_base(period);
      repeat (PHASE_ITEMS) begin
        if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
        random_item();
      end
      settle();
    end

    $display("Run covered %0d pixel writes and %0d refresh ticks (%0d full frames).",
             pixel_writes, refresh_ticks, refresh_ticks / (PLANES_DEF * SCAN_ROWS));
    $display("%0d column beats matched; hold base swept over 0, 1, 8191, random, reset.",
             column_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
